>>> rtl/core/pdbfv_pkg.sv
// Shared constants and controller/datapath interface types for the PCM DC-block/fade/volume path.
package pdbfv_pkg;

  // Fade-in length in samples. The divide by it is a shift, so keep it a power of two.
  localparam int unsigned FADE_LEN   = 64;
  localparam int unsigned FADE_SHIFT = $clog2(FADE_LEN);
  localparam int unsigned FADE_W     = $clog2(FADE_LEN + 1);

  // High-pass feedback coefficient, 0.995 in Q15
  localparam logic [14:0] HP_COEF = 15'd32604;

  // Reset value of the gain register, Q15
  localparam logic [15:0] GAIN_RESET = 16'd8231;

  // Datapath widths
  localparam int unsigned X_W   = 16;                   // input sample
  localparam int unsigned Y_W   = 40;                   // filter state, Q.16
  localparam int unsigned YH_W  = Y_W / 2;              // half of the state for the split multiply
  localparam int unsigned PH_W  = YH_W + 15;            // partial product width
  localparam int unsigned PS_W  = PH_W + YH_W;          // full feedback product width
  localparam int unsigned YS_W  = Y_W + 2;              // filter sum before saturation
  localparam int unsigned YI_W  = Y_W - 16;             // integer part of the filter output
  localparam int unsigned FP_W  = YI_W + FADE_W + 1;    // fade product
  localparam int unsigned GP_W  = YI_W + 17;            // gain product
  localparam int unsigned SV_W  = GP_W - 15;            // gain product after the Q15 shift

  // Request kinds carried on the input tuser bit
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic flush;     // clear pairing, filter state and fade
    logic load_low;  // hold the low byte
    logic load_x;    // complete a sample from the held byte and this byte
    logic mul_lo;    // feedback product, low half of y1
    logic mul_hi;    // feedback product, high half of y1
    logic sum;       // combine halves and shift by 15
    logic filt;      // form and saturate y, update filter state
    logic trunc;     // integer part of y, toward zero
    logic fade;      // multiply by the fade factor
    logic div;       // divide by the fade length, toward zero
    logic gain;      // multiply by the gain
    logic emit;      // shift, saturate and load the output register
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic low_held;  // a low byte waits for its high byte
    logic out_free;  // output register can take a sample this cycle
  } dp_stat_t;

endpackage

>>> rtl/core/pdbfv_ctrl.sv
// Sequencer for the PCM audio path: accepts bytes and steps the datapath through one sample.
module pdbfv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_user_i,
  output logic                s_ready_o,
  input  pdbfv_pkg::dp_stat_t stat_i,
  output pdbfv_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_LO = 4'd1;
  localparam logic [3:0] S_MUL_HI = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_FILT   = 4'd4;
  localparam logic [3:0] S_TRUNC  = 4'd5;
  localparam logic [3:0] S_FADE   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_GAIN   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          if (s_user_i == pdbfv_pkg::REQ_FLUSH) begin
            cmd_o.flush = 1'b1;
          end else if (!stat_i.low_held) begin
            cmd_o.load_low = 1'b1;
          end else begin
            cmd_o.load_x = 1'b1;
            state_d      = S_MUL_LO;
          end
        end
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = S_TRUNC;
      end
      S_TRUNC: begin
        cmd_o.trunc = 1'b1;
        state_d     = S_FADE;
      end
      S_FADE: begin
        cmd_o.fade = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_GAIN;
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // Wait here until the previous sample has been taken
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A completed byte pair always starts the arithmetic sequence
  a_pair_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_x |=> (state_q == S_MUL_LO))
    else $error("byte pair did not start the sample sequence");

  // The sequence reaches the output step a fixed time after the pair completes
  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_x |-> ##9 (state_q == S_OUT))
    else $error("sample sequence length broken");

  // At most one command is issued per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

>>> rtl/core/pdbfv_datapath.sv
// Datapath for the PCM audio path: byte pairing, DC-block filter, fade-in, gain and output register.
module pdbfv_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdbfv_pkg::dp_cmd_t  cmd_i,
  output pdbfv_pkg::dp_stat_t stat_o,
  input  logic [7:0]          byte_i,
  input  logic                cfg_valid_i,
  input  logic [15:0]         cfg_data_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [15:0]         m_data_o
);

  // Control and architectural state
  logic                                  low_held_q;
  logic [7:0]                            held_q;
  logic [15:0]                           gain_q;
  logic signed [pdbfv_pkg::X_W-1:0]      x1_q;
  logic signed [pdbfv_pkg::Y_W-1:0]      y1_q;
  logic [pdbfv_pkg::FADE_W-1:0]          fade_q;
  logic                                  m_valid_q;
  logic [15:0]                           m_data_q;

  // Working registers
  logic signed [pdbfv_pkg::X_W-1:0]      x_q;
  logic [pdbfv_pkg::PH_W-1:0]            plo_q;
  logic signed [pdbfv_pkg::PH_W-1:0]     phi_q;
  logic signed [pdbfv_pkg::Y_W-1:0]      sh_q;
  logic signed [pdbfv_pkg::YI_W-1:0]     yi_q;
  logic signed [pdbfv_pkg::FP_W-1:0]     fprod_q;
  logic signed [pdbfv_pkg::YI_W-1:0]     q_q;
  logic signed [pdbfv_pkg::GP_W-1:0]     gprod_q;

  // Combinational step results
  logic [pdbfv_pkg::PH_W-1:0]            plo_d;
  logic signed [pdbfv_pkg::PH_W-1:0]     phi_d;
  logic signed [pdbfv_pkg::PS_W-1:0]     psum;
  logic signed [pdbfv_pkg::X_W:0]        diff;
  logic signed [pdbfv_pkg::YS_W-1:0]     ysum;
  logic signed [pdbfv_pkg::Y_W-1:0]      ysat;
  logic signed [pdbfv_pkg::YI_W-1:0]     yi_d;
  logic                                  fade_on;
  logic [pdbfv_pkg::FADE_W-1:0]          factor;
  logic signed [pdbfv_pkg::FP_W-1:0]     fprod_d;
  logic                                  div_fix;
  logic signed [pdbfv_pkg::YI_W-1:0]     q_d;
  logic signed [pdbfv_pkg::GP_W-1:0]     gprod_d;
  logic signed [pdbfv_pkg::SV_W-1:0]     sv;
  logic [15:0]                           out_d;

  // Feedback product split into two half-width multiplies
  assign plo_d = pdbfv_pkg::PH_W'(y1_q[pdbfv_pkg::YH_W-1:0])
               * pdbfv_pkg::PH_W'(pdbfv_pkg::HP_COEF);
  assign phi_d = pdbfv_pkg::PH_W'($signed(y1_q[pdbfv_pkg::Y_W-1:pdbfv_pkg::YH_W]))
               * pdbfv_pkg::PH_W'($signed({1'b0, pdbfv_pkg::HP_COEF}));

  // Recombine and floor-shift by 15
  assign psum = $signed({phi_q, {pdbfv_pkg::YH_W{1'b0}}})
              + $signed(pdbfv_pkg::PS_W'(plo_q));

  // Filter sum: (x - x1) * 65536 + feedback, saturated to the state width
  assign diff = (pdbfv_pkg::X_W + 1)'(x_q) - (pdbfv_pkg::X_W + 1)'(x1_q);
  assign ysum = $signed({{(pdbfv_pkg::YS_W - pdbfv_pkg::X_W - 17){diff[pdbfv_pkg::X_W]}},
                         diff, 16'b0})
              + pdbfv_pkg::YS_W'(sh_q);

  always_comb begin
    if (ysum[pdbfv_pkg::YS_W-1:pdbfv_pkg::Y_W-1] == {3{ysum[pdbfv_pkg::Y_W-1]}}) begin
      ysat = ysum[pdbfv_pkg::Y_W-1:0];
    end else if (ysum[pdbfv_pkg::YS_W-1]) begin
      ysat = {1'b1, {(pdbfv_pkg::Y_W-1){1'b0}}};
    end else begin
      ysat = {1'b0, {(pdbfv_pkg::Y_W-1){1'b1}}};
    end
  end

  // Integer part toward zero: floor, plus one for a negative value with a fraction
  assign yi_d = $signed(y1_q[pdbfv_pkg::Y_W-1:16])
              + pdbfv_pkg::YI_W'(y1_q[pdbfv_pkg::Y_W-1] && (y1_q[15:0] != 16'd0));

  // Fade factor: k+1 while fading, otherwise the full length so the divide is exact
  assign fade_on = (fade_q < pdbfv_pkg::FADE_W'(pdbfv_pkg::FADE_LEN));
  assign factor  = fade_on ? (fade_q + pdbfv_pkg::FADE_W'(1))
                           : pdbfv_pkg::FADE_W'(pdbfv_pkg::FADE_LEN);
  assign fprod_d = pdbfv_pkg::FP_W'(yi_q) * $signed({1'b0, factor});

  // Divide by the fade length toward zero
  assign div_fix = fprod_q[pdbfv_pkg::FP_W-1]
                && ((fprod_q & pdbfv_pkg::FP_W'(pdbfv_pkg::FADE_LEN - 1)) != '0);
  assign q_d = pdbfv_pkg::YI_W'(fprod_q >>> pdbfv_pkg::FADE_SHIFT)
             + pdbfv_pkg::YI_W'(div_fix);

  // Gain multiply
  assign gprod_d = pdbfv_pkg::GP_W'(q_q) * pdbfv_pkg::GP_W'($signed({1'b0, gain_q}));

  // Floor-shift by 15 and saturate to int16
  assign sv = gprod_q[pdbfv_pkg::GP_W-1:15];
  always_comb begin
    if (sv[pdbfv_pkg::SV_W-1:15] == {(pdbfv_pkg::SV_W-15){sv[15]}}) begin
      out_d = sv[15:0];
    end else if (sv[pdbfv_pkg::SV_W-1]) begin
      out_d = 16'h8000;
    end else begin
      out_d = 16'h7fff;
    end
  end

  // State with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_held_q <= 1'b0;
      gain_q     <= pdbfv_pkg::GAIN_RESET;
      x1_q       <= '0;
      y1_q       <= '0;
      fade_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if (cmd_i.flush) begin
        low_held_q <= 1'b0;
        x1_q       <= '0;
        y1_q       <= '0;
        fade_q     <= '0;
      end
      if (cmd_i.load_low) begin
        low_held_q <= 1'b1;
      end
      if (cmd_i.load_x) begin
        low_held_q <= 1'b0;
      end
      if (cmd_i.filt) begin
        x1_q <= x_q;
        y1_q <= ysat;
      end
      if (cmd_i.fade && fade_on) begin
        fade_q <= fade_q + pdbfv_pkg::FADE_W'(1);
      end
      // Output register: drop on transfer, load on emit
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_low) held_q  <= byte_i;
    if (cmd_i.load_x)   x_q     <= {byte_i, held_q};
    if (cmd_i.mul_lo)   plo_q   <= plo_d;
    if (cmd_i.mul_hi)   phi_q   <= phi_d;
    if (cmd_i.sum)      sh_q    <= psum[pdbfv_pkg::PS_W-1:15];
    if (cmd_i.trunc)    yi_q    <= yi_d;
    if (cmd_i.fade)     fprod_q <= fprod_d;
    if (cmd_i.div)      q_q     <= q_d;
    if (cmd_i.gain)     gprod_q <= gprod_d;
    if (cmd_i.emit)     m_data_q <= out_d;
  end

  assign stat_o.low_held = low_held_q;
  assign stat_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o       = m_valid_q;
  assign m_data_o        = m_data_q;

  // A new sample never overwrites one that has not been transferred
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!m_valid_q || m_ready_i))
    else $error("output register overwritten");

  // The fade counter stops at the fade length
  a_fade_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_q <= pdbfv_pkg::FADE_W'(pdbfv_pkg::FADE_LEN))
    else $error("fade counter ran past its end");

  // A flush clears the pairing, the filter state and the fade
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (!low_held_q && (fade_q == '0) && (y1_q == '0) && (x1_q == '0)))
    else $error("flush left playback state behind");

endmodule

>>> rtl/core/pcm_dc_block_fade_volume_top.sv
// Top level of the PCM audio path: byte stream in, DC-blocked, faded, gain-scaled samples out.
//
// Bytes of little-endian 16-bit PCM enter on the s_axis side, one byte per transfer; a low byte
// is held until its high byte arrives, across packet boundaries. A byte that completes no sample,
// and a flush (tuser high), is taken in the idle state. A byte that completes a sample holds off
// the next byte until the sequencer is idle again: it runs the sample through two half-width
// multiplies for the filter feedback, the filter sum, truncation, the fade multiply and
// divide, the gain multiply and the final saturation, one step per cycle. The finished sample
// waits in an output register, so the next bytes are taken while it is pending; the sequence
// holds in its last step only while an earlier sample is still untaken. The gain register is
// written through the cfg channel, which is always ready; write it only while the block is idle.
module pcm_dc_block_fade_volume_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] req_type (1 = flush)
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  // Gain register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] volume gain, Q15
);

  pdbfv_pkg::dp_cmd_t  cmd;
  pdbfv_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  pdbfv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_user_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Arithmetic and state
  pdbfv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .byte_i      (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
